// ===== hw/rtl/hba_pkg.sv =====
// ----------------------------------------------------------------------------
// hba_pkg
// Shared types and constants for the histogram bin accumulator.
// ----------------------------------------------------------------------------
package hba_pkg;

    // bin store geometry
    localparam int NUM_BINS    = 1024;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_W       = $clog2(NUM_BINS);

    // field widths
    localparam int DATA_W    = 32;
    localparam int OUT_W     = 32;
    localparam int SEL_W     = 10;
    localparam int BCOUNT_W  = 11;
    localparam int CFG_ADDR_W = 4;

    // item actions
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_X_ORIGIN  = 2'd0;
    localparam logic [1:0] REG_INV_WIDTH = 2'd1;
    localparam logic [1:0] REG_BIN_COUNT = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_LOOK,
        ST_MODIFY
    } state_t;

    // stage enables from the controller to the bin mapper
    typedef struct packed {
        logic load;
        logic mul;
        logic look;
    } map_ctrl_t;

    // bin mapper results
    typedef struct packed {
        logic [BIN_W-1:0] rd_addr;
        logic [DATA_W-1:0] bin;
        logic              hit;
        logic              is_add;
        logic              is_clear;
    } map_res_t;

endpackage

// ===== hw/rtl/hba_ram.sv =====
// ----------------------------------------------------------------------------
// hba_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hba_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hba_bin_map.sv =====
// ----------------------------------------------------------------------------
// hba_bin_map
// Maps a sample to a bin: origin subtract, Q16.16 multiply, range check.
// ----------------------------------------------------------------------------
module hba_bin_map import hba_pkg::*; (
    input  logic                aclk,
    input  map_ctrl_t           ctrl,
    input  logic [1:0]          action,
    input  logic [DATA_W-1:0]   sample,
    input  logic [SEL_W-1:0]    bin_select,
    input  logic [DATA_W-1:0]   x_origin,
    input  logic [DATA_W-1:0]   inv_width,
    input  logic [BCOUNT_W-1:0] bin_count,
    output map_res_t            res
);

    logic [1:0]          act_reg;
    logic [SEL_W-1:0]    sel_reg;
    logic [DATA_W:0]     diff_reg;
    logic [2*DATA_W-1:0] prod_reg;
    logic                drop_reg;
    logic [DATA_W-1:0]   bin_reg;
    logic                hit_reg;

    logic [DATA_W:0]     diff_next;
    logic [DATA_W-1:0]   bin_look;
    logic                in_limit;
    logic                hit_look;

    // exact 33-bit difference at transfer
    assign diff_next = {sample[DATA_W-1], sample} - {x_origin[DATA_W-1], x_origin};

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            act_reg  <= action;
            sel_reg  <= bin_select;
            diff_reg <= diff_next;
        end
    end

    // product stage, negative differences give zero
    always_ff @(posedge aclk) begin
        if (ctrl.mul) begin
            if (diff_reg[DATA_W]) begin
                prod_reg <= '0;
            end else begin
                prod_reg <= (2*DATA_W)'(diff_reg[DATA_W-1:0]) * (2*DATA_W)'(inv_width);
            end
            drop_reg <= diff_reg[DATA_W] && (inv_width != '0);
        end
    end

    // bin selection and range check
    always_comb begin
        if (act_reg == ACT_ADD) begin
            bin_look = prod_reg[2*DATA_W-1:DATA_W];
        end else begin
            bin_look = DATA_W'(sel_reg);
        end
        in_limit = (bin_look < DATA_W'(bin_count)) && (bin_look < DATA_W'(NUM_BINS));
        hit_look = in_limit && !((act_reg == ACT_ADD) && drop_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.look) begin
            bin_reg <= bin_look;
            hit_reg <= hit_look;
        end
    end

    assign res.rd_addr  = bin_look[BIN_W-1:0];
    assign res.bin      = bin_reg;
    assign res.hit      = hit_reg;
    assign res.is_add   = (act_reg == ACT_ADD);
    assign res.is_clear = (act_reg == ACT_CLEAR);

endmodule

// ===== hw/rtl/histogram_bin_accumulator.sv =====
// ----------------------------------------------------------------------------
// histogram_bin_accumulator
// Histogram engine: bins Q16.16 samples into a counter memory, reads and
// clears single bins, and keeps a saturating running total.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload
//   s_*       in         tuser: action; tdata: sample, bin_select
//   m_*       out        tuser: in_range; tdata: bin_number, bin_value, total
//   apb       in/out     x_origin @0x0, inverse_bin_width @0x4, bin_count @0x8
//
// Each item passes four steps: transfer, multiply, bin read, update. A new
// item is taken only after the update, as the single read-modify-write on the bin memory serialises items.
// After reset a clearing pass zeroes the bin memory with
// s_tready low; configuration writes are taken throughout.
// A stalled result holds the update step until the output register frees.
// ----------------------------------------------------------------------------
module histogram_bin_accumulator import hba_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [1:0]            s_tuser,  // [1:0] action
    input  logic [47:0]           s_tdata,  // [31:0] sample, [41:32] bin_select
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_tuser,  // [0] in_range
    output logic [79:0]           m_tdata,  // [9:0] bin_number, [41:10] bin_value,
                                            // [73:42] total_value
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    state_t state_reg, state_next;

    logic [DATA_W-1:0]      x_origin_reg;
    logic [DATA_W-1:0]      inv_width_reg;
    logic [BCOUNT_W-1:0]    bin_count_reg;
    logic [BIN_W-1:0]       clr_idx_reg;
    logic [COUNT_WIDTH-1:0] total_reg;
    logic [COUNT_WIDTH-1:0] total_next;

    logic                   m_valid_reg;
    logic [SEL_W-1:0]       m_bin_reg;
    logic                   m_hit_reg;
    logic [OUT_W-1:0]       m_val_reg;
    logic [OUT_W-1:0]       m_total_reg;

    map_ctrl_t              map_ctrl;
    map_res_t               map_res;

    logic                   out_free;
    logic                   mod_fire;
    logic                   ram_we;
    logic                   ram_re;
    logic [BIN_W-1:0]       ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic                   upd_we;
    logic [COUNT_WIDTH-1:0] upd_wdata;
    logic [COUNT_WIDTH-1:0] res_val;
    logic [SEL_W-1:0]       res_bin;
    logic                   cfg_wr;

    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg  <= '0;
            inv_width_reg <= DATA_W'(65536);
            bin_count_reg <= BCOUNT_W'(1024);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_X_ORIGIN:  x_origin_reg  <= pwdata;
                REG_INV_WIDTH: inv_width_reg <= pwdata;
                REG_BIN_COUNT: bin_count_reg <= pwdata[BCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_X_ORIGIN:  prdata = x_origin_reg;
            REG_INV_WIDTH: prdata = inv_width_reg;
            REG_BIN_COUNT: prdata = 32'(bin_count_reg);
            default:       prdata = '0;
        endcase
    end

    // output register frees when empty or taken this cycle
    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_idx_reg == BIN_W'(NUM_BINS - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid) state_next = ST_MUL;
            ST_MUL:    state_next = ST_LOOK;
            ST_LOOK:   state_next = ST_MODIFY;
            ST_MODIFY: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        s_tready      = 1'b0;
        map_ctrl.load = 1'b0;
        map_ctrl.mul  = 1'b0;
        map_ctrl.look = 1'b0;
        ram_re        = 1'b0;
        mod_fire      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  ;
            ST_IDLE: begin
                s_tready      = 1'b1;
                map_ctrl.load = s_tvalid;
            end
            ST_MUL:    map_ctrl.mul = 1'b1;
            ST_LOOK: begin
                map_ctrl.look = 1'b1;
                ram_re        = 1'b1;
            end
            ST_MODIFY: mod_fire = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    // sample to bin mapping
    hba_bin_map u_bin_map (
        .aclk       (aclk),
        .ctrl       (map_ctrl),
        .action     (s_tuser),
        .sample     (s_tdata[31:0]),
        .bin_select (s_tdata[41:32]),
        .x_origin   (x_origin_reg),
        .inv_width  (inv_width_reg),
        .bin_count  (bin_count_reg),
        .res        (map_res)
    );

    // bin update: saturating increment, read, or read and clear
    always_comb begin
        upd_we     = 1'b0;
        upd_wdata  = ram_rdata;
        res_val    = '0;
        total_next = total_reg;
        res_bin    = map_res.bin[SEL_W-1:0];
        if (map_res.hit) begin
            if (map_res.is_add) begin
                res_val = ram_rdata;
                if (ram_rdata != CountMax) begin
                    upd_we    = 1'b1;
                    upd_wdata = ram_rdata + 1'b1;
                    res_val   = ram_rdata + 1'b1;
                    if (total_reg != CountMax) begin
                        total_next = total_reg + 1'b1;
                    end
                end
            end else begin
                res_val = ram_rdata;
                if (map_res.is_clear) begin
                    upd_we     = 1'b1;
                    upd_wdata  = '0;
                    total_next = (total_reg > ram_rdata) ? total_reg - ram_rdata : '0;
                end
            end
        end else if (map_res.is_add) begin
            res_bin = '0;
        end
    end

    // memory write port: clearing pass or update
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = mod_fire && upd_we;
            ram_waddr = map_res.bin[BIN_W-1:0];
            ram_wdata = upd_wdata;
        end
    end

    hba_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BINS)
    ) u_bin_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (map_res.rd_addr),
        .rdata (ram_rdata)
    );

    // running total
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (mod_fire) begin
            total_reg <= total_next;
        end
    end

    // result output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (mod_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mod_fire) begin
            m_bin_reg   <= res_bin;
            m_hit_reg   <= map_res.hit;
            m_val_reg   <= OUT_W'(res_val);
            m_total_reg <= OUT_W'(total_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = {6'b0, m_total_reg, m_val_reg, m_bin_reg};

endmodule
